FILE: src/pprd_pkg.sv
`timescale 1ns / 1ps

package pprd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int SMOOTH_W = 24;
    localparam int BPM_W    = 16;
    localparam int WIN_W    = 7;
    localparam int THR_W    = 24;
    localparam int REFR_W   = 16;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;
    // window is at most 127, so the sum of 16-bit samples fits in 23 bits
    localparam int SUM_W    = SAMPLE_W + WIN_W;
    localparam int DIV_W    = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // 60000 bpm-ms scaled by 256 for Q8.8
    localparam logic [DIV_W-1:0] RATE_NUM = 32'd15360000;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACT   = 2'd2;

    typedef enum logic [1:0] {
        SLOPE_NONE,
        SLOPE_RISING,
        SLOPE_FALLING
    } slope_t;

    typedef enum logic {
        F_IDLE,
        F_UPDATE
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SMOOTH,
        B_DETECT,
        B_RATE,
        B_OUT
    } back_state_t;

    // one queued item: window sum after the sample, and its timestamp
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [TIME_W-1:0] time_ms;
    } item_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: src/pulse_peak_rate_detector_top.sv
`timescale 1ns / 1ps

// Pulse peak and heart rate detector.
// Input stream (s_axis): one transaction per pulse sample, tdata carries
//   raw_sample and the millisecond timestamp time_ms.
// Output stream (m_axis): exactly one transaction per input sample, tdata
//   carries the Q16.8 moving average and the Q8.8 rate in beats per minute,
//   tuser flags that the rate is valid (second or later peak).
// Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 window length, 1 level threshold, 2 refractory time in ms); write only
//   while the block is idle. A window write also empties the sample ring.
// Timing: the front takes a sample only from its idle state and passes an
//   update state before it can take the next, into a 2-deep queue; the back
//   shares one serial divider (1 quotient bit per cycle) and takes each item
//   through its smoothing divide, detect, rate divide (only when a peak
//   produces a rate) and output states before it pops the next; the result
//   is held in the output register that drives m_axis_tvalid.
// Reset: rst_n clears the ring (through a fill flag, no sweep), running sum,
//   detector state and registers to window 8, threshold 0, refractory 300.
// Stall: a result waits in the output register while m_axis_tready is low;
//   the back then holds, the queue fills and s_axis_tready drops.
module pulse_peak_rate_detector_top
#(
    parameter int MAX_WINDOW = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // [15:0] raw_sample, [47:16] time_ms
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [23:0] smoothed_value, [39:24] beats_per_minute
    output logic [0:0]  m_axis_tuser,  // [0] rate_valid
    input  logic                              cfg_we,
    input  logic [pprd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pprd_pkg::CFG_W-1:0]        cfg_data
);

    // the window register is 7 bits wide, so the usable window tops out at 127
    localparam int WIN_EFF = (MAX_WINDOW > 127) ? 127 : MAX_WINDOW;
    localparam logic [pprd_pkg::WIN_W-1:0] WIN_CAP   = pprd_pkg::WIN_W'(WIN_EFF);
    localparam logic [pprd_pkg::WIN_W-1:0] WIN_RESET =
        pprd_pkg::WIN_W'((WIN_EFF < 8) ? WIN_EFF : 8);

    logic [pprd_pkg::WIN_W-1:0]  window_reg;
    logic [pprd_pkg::THR_W-1:0]  threshold_reg;
    logic [pprd_pkg::REFR_W-1:0] refract_reg;
    logic [pprd_pkg::WIN_W-1:0]  window_next;
    logic                        window_wr;

    logic                        q_push;
    logic                        q_pop;
    logic                        q_full;
    logic                        q_empty;
    pprd_pkg::item_t             q_item;
    pprd_pkg::item_t             q_head;
    pprd_pkg::div_req_t          div_req;
    pprd_pkg::div_rsp_t          div_rsp;

    logic [pprd_pkg::SMOOTH_W-1:0] smoothed;
    logic                          rate_valid;
    logic [pprd_pkg::BPM_W-1:0]    bpm;

    assign window_wr = cfg_we && (cfg_index == pprd_pkg::CFG_WINDOW);

    // zero acts as one, anything above the cap acts as the cap
    always_comb
    begin
        window_next = cfg_data[pprd_pkg::WIN_W-1:0];
        if (window_next == '0)
            window_next = pprd_pkg::WIN_W'(1);
        else if (window_next > WIN_CAP)
            window_next = WIN_CAP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WIN_RESET;
            threshold_reg <= '0;
            refract_reg   <= pprd_pkg::REFR_W'(300);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pprd_pkg::CFG_WINDOW:    window_reg    <= window_next;
                pprd_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data[pprd_pkg::THR_W-1:0];
                pprd_pkg::CFG_REFRACT:   refract_reg   <= cfg_data[pprd_pkg::REFR_W-1:0];
                default:                 ;
            endcase
        end
    end

    pprd_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .window  (window_reg),
        .clear   (window_wr),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .sample  (s_axis_tdata[15:0]),
        .time_ms (s_axis_tdata[47:16]),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_item)
    );

    pprd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    pprd_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pprd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .window     (window_reg),
        .threshold  (threshold_reg),
        .refract    (refract_reg),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .smoothed   (smoothed),
        .rate_valid (rate_valid),
        .bpm        (bpm)
    );

    assign m_axis_tdata = {bpm, smoothed};
    assign m_axis_tuser = rate_valid;

endmodule

FILE: src/pprd_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
// Divisor zero yields an all-ones quotient.
module pprd_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  pprd_pkg::div_req_t req,
    output pprd_pkg::div_rsp_t rsp
);

    logic [pprd_pkg::DIV_W-1:0]     quo_reg;
    logic [pprd_pkg::DIV_W-1:0]     rem_reg;
    logic [pprd_pkg::DIV_W-1:0]     dvs_reg;
    logic [pprd_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           run_reg;
    logic                           done_reg;

    logic [pprd_pkg::DIV_W:0]   rem_sh;
    logic                       ge;
    logic [pprd_pkg::DIV_W:0]   rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[pprd_pkg::DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= pprd_pkg::DIV_CNT_W'(pprd_pkg::DIV_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == pprd_pkg::DIV_CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[pprd_pkg::DIV_W-2:0], ge};
            rem_reg <= ge ? rem_sub[pprd_pkg::DIV_W-1:0] : rem_sh[pprd_pkg::DIV_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg && $past(run_reg))
        else $error("divider done without a finished run");

endmodule

FILE: src/pprd_queue.sv
`timescale 1ns / 1ps

// Two-entry queue between front and back.
module pprd_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pprd_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output pprd_pkg::item_t head
);

    pprd_pkg::item_t slot_mem [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = slot_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_mem[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop) && !(pop && empty))
        else $error("queue overflow or underflow");

endmodule

FILE: src/pprd_front.sv
`timescale 1ns / 1ps

// Front: takes samples, keeps the ring buffer and the running window sum.
module pprd_front
#(
    parameter int MAX_WINDOW = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pprd_pkg::WIN_W-1:0]    window,
    input  logic                          clear,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pprd_pkg::SAMPLE_W-1:0] sample,
    input  logic [pprd_pkg::TIME_W-1:0]   time_ms,
    input  logic                          q_full,
    output logic                          q_push,
    output pprd_pkg::item_t               q_item
);

    localparam int PW = $clog2(MAX_WINDOW);

    pprd_pkg::front_state_t state_reg;
    pprd_pkg::front_state_t state_next;

    logic [pprd_pkg::SAMPLE_W-1:0] ring_mem [MAX_WINDOW];
    logic [pprd_pkg::SAMPLE_W-1:0] rd_reg;
    logic [pprd_pkg::SAMPLE_W-1:0] sample_reg;
    logic [pprd_pkg::TIME_W-1:0]   time_reg;
    logic [PW-1:0]                 pos_reg;
    logic [pprd_pkg::SUM_W-1:0]    sum_reg;
    logic                          wrapped_reg;

    logic                          accept;
    logic [pprd_pkg::SUM_W-1:0]    sum_next;
    logic [pprd_pkg::SAMPLE_W-1:0] old_sample;
    logic                          pos_last;

    assign accept = s_valid && s_ready;

    // entries read before the first wrap since a clear hold zero
    assign old_sample = wrapped_reg ? rd_reg : '0;
    assign sum_next   = sum_reg - pprd_pkg::SUM_W'(old_sample)
                        + pprd_pkg::SUM_W'(sample_reg);
    assign pos_last   = (32'(pos_reg) + 32'd1) >= 32'(window);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pprd_pkg::F_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        s_ready    = 1'b0;
        q_push     = 1'b0;
        case (state_reg)
            pprd_pkg::F_IDLE:
            begin
                s_ready = !q_full;
                if (s_valid && !q_full)
                    state_next = pprd_pkg::F_UPDATE;
            end
            pprd_pkg::F_UPDATE:
            begin
                q_push     = 1'b1;
                state_next = pprd_pkg::F_IDLE;
            end
            default:
                state_next = pprd_pkg::F_IDLE;
        endcase
    end

    assign q_item.sum     = sum_next;
    assign q_item.time_ms = time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            sum_reg     <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (clear)
        begin
            pos_reg     <= '0;
            sum_reg     <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (state_reg == pprd_pkg::F_UPDATE)
        begin
            sum_reg <= sum_next;
            if (pos_last)
            begin
                pos_reg     <= '0;
                wrapped_reg <= 1'b1;
            end
            else
                pos_reg <= pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg     <= ring_mem[pos_reg];
            sample_reg <= sample;
            time_reg   <= time_ms;
        end
        if (state_reg == pprd_pkg::F_UPDATE)
            ring_mem[pos_reg] <= sample_reg;
    end

    a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < 32'(window))
        else $error("ring position outside window");

endmodule

FILE: src/pprd_back.sv
`timescale 1ns / 1ps

// Back: smoothing divide, slope and peak tracking, rate divide, result register.
module pprd_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pprd_pkg::WIN_W-1:0]    window,
    input  logic [pprd_pkg::THR_W-1:0]    threshold,
    input  logic [pprd_pkg::REFR_W-1:0]   refract,
    input  logic                          q_empty,
    input  pprd_pkg::item_t               q_head,
    output logic                          q_pop,
    output pprd_pkg::div_req_t            div_req,
    input  pprd_pkg::div_rsp_t            div_rsp,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pprd_pkg::SMOOTH_W-1:0] smoothed,
    output logic                          rate_valid,
    output logic [pprd_pkg::BPM_W-1:0]    bpm
);

    pprd_pkg::back_state_t state_reg;
    pprd_pkg::back_state_t state_next;

    logic [pprd_pkg::TIME_W-1:0]   time_reg;
    logic [pprd_pkg::SMOOTH_W-1:0] smooth_reg;
    logic                          rvalid_reg;
    logic [pprd_pkg::BPM_W-1:0]    rate_reg;

    logic [pprd_pkg::SMOOTH_W-1:0] prior_reg;
    pprd_pkg::slope_t              slope_reg;
    logic                          seen_reg;
    logic                          refr_reg;
    logic [pprd_pkg::TIME_W-1:0]   last_reg;

    logic                          m_valid_reg;
    logic [pprd_pkg::SMOOTH_W-1:0] out_smooth_reg;
    logic                          out_rvalid_reg;
    logic [pprd_pkg::BPM_W-1:0]    out_bpm_reg;

    logic                          below;
    logic [pprd_pkg::TIME_W-1:0]   elapsed;
    logic                          hold;
    pprd_pkg::slope_t              new_slope;
    logic                          peak;
    logic                          load_out;
    logic [pprd_pkg::BPM_W-1:0]    rate_sat;

    assign below   = smooth_reg < threshold;
    assign elapsed = time_reg - last_reg;
    assign hold    = refr_reg && (elapsed < pprd_pkg::TIME_W'(refract));
    assign peak    = (slope_reg == pprd_pkg::SLOPE_RISING)
                     && (new_slope == pprd_pkg::SLOPE_FALLING);
    assign rate_sat = (|div_rsp.quotient[pprd_pkg::DIV_W-1:pprd_pkg::BPM_W])
                      ? '1 : div_rsp.quotient[pprd_pkg::BPM_W-1:0];

    always_comb
    begin
        if (smooth_reg > prior_reg)
            new_slope = pprd_pkg::SLOPE_RISING;
        else if (smooth_reg < prior_reg)
            new_slope = pprd_pkg::SLOPE_FALLING;
        else
            new_slope = slope_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pprd_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        q_pop            = 1'b0;
        load_out         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {1'b0, q_head.sum, 8'd0};
        div_req.divisor  = pprd_pkg::DIV_W'(window);
        case (state_reg)
            pprd_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop         = 1'b1;
                    div_req.start = 1'b1;
                    state_next    = pprd_pkg::B_SMOOTH;
                end
            end
            pprd_pkg::B_SMOOTH:
            begin
                if (div_rsp.done)
                    state_next = pprd_pkg::B_DETECT;
            end
            pprd_pkg::B_DETECT:
            begin
                // interval of zero gives an all-ones quotient, saturated by rate_sat
                div_req.dividend = pprd_pkg::RATE_NUM;
                div_req.divisor  = elapsed;
                if (!below && !hold && peak && seen_reg)
                begin
                    div_req.start = 1'b1;
                    state_next    = pprd_pkg::B_RATE;
                end
                else
                    state_next = pprd_pkg::B_OUT;
            end
            pprd_pkg::B_RATE:
            begin
                if (div_rsp.done)
                    state_next = pprd_pkg::B_OUT;
            end
            pprd_pkg::B_OUT:
            begin
                if (!m_valid_reg || m_ready)
                begin
                    load_out   = 1'b1;
                    state_next = pprd_pkg::B_IDLE;
                end
            end
            default:
                state_next = pprd_pkg::B_IDLE;
        endcase
    end

    // detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg <= '0;
            slope_reg <= pprd_pkg::SLOPE_NONE;
            seen_reg  <= 1'b0;
            refr_reg  <= 1'b0;
            last_reg  <= '0;
        end
        else if (state_reg == pprd_pkg::B_DETECT)
        begin
            if (below)
                slope_reg <= pprd_pkg::SLOPE_NONE;
            else if (!hold)
            begin
                refr_reg  <= 1'b0;
                slope_reg <= new_slope;
                prior_reg <= smooth_reg;
                if (peak)
                begin
                    seen_reg <= 1'b1;
                    last_reg <= time_reg;
                    refr_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (load_out)
            m_valid_reg <= 1'b1;
        else if (m_ready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            time_reg <= q_head.time_ms;
        if (state_reg == pprd_pkg::B_SMOOTH && div_rsp.done)
            smooth_reg <= div_rsp.quotient[pprd_pkg::SMOOTH_W-1:0];
        if (state_reg == pprd_pkg::B_DETECT)
        begin
            rvalid_reg <= 1'b0;
            rate_reg   <= '0;
        end
        else if (state_reg == pprd_pkg::B_RATE && div_rsp.done)
        begin
            rvalid_reg <= 1'b1;
            rate_reg   <= rate_sat;
        end
        if (load_out)
        begin
            out_smooth_reg <= smooth_reg;
            out_rvalid_reg <= rvalid_reg;
            out_bpm_reg    <= rate_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign smoothed   = out_smooth_reg;
    assign rate_valid = out_rvalid_reg;
    assign bpm        = out_bpm_reg;

    a_rate_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !out_rvalid_reg) |-> (out_bpm_reg == '0))
        else $error("rate nonzero without rate_valid");

    a_div_start_idle_or_detect: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (state_reg == pprd_pkg::B_IDLE || state_reg == pprd_pkg::B_DETECT))
        else $error("divider started outside a dispatch state");

endmodule

FILE: dv/tb_pulse_peak_rate_detector_top.sv
`timescale 1ns / 1ps

// Pulse peak / heart rate detector testbench.
// Samples go in over s_axis, one result comes back per sample over m_axis.
// A cycle-free model kept in this module mirrors the ring buffer, the moving
// average and the slope / refractory / rate logic; every input transaction
// pushes its predicted result, and every output transaction is checked field
// by field against the oldest prediction.
module tb_pulse_peak_rate_detector_top;

    localparam int          WINDOW_MAX       = 64;
    localparam int unsigned CYCLE_LIMIT      = 1_000_000;
    localparam int unsigned MAX_PRINTS       = 40;
    localparam int unsigned RANDOM_SAMPLES   = 1400;
    localparam int unsigned DRAIN_CYCLES     = 80;

    localparam int unsigned                   WINDOW_AT_RESET  = 8;
    localparam logic [pprd_pkg::THR_W-1:0]    THRESH_AT_RESET  = '0;
    localparam logic [pprd_pkg::REFR_W-1:0]   REFRACT_AT_RESET = 16'd300;

    // register index the block has no register for
    localparam logic [pprd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [pprd_pkg::SMOOTH_W-1:0] smoothed;
        logic                          rate_valid;
        logic [pprd_pkg::BPM_W-1:0]    bpm;
    } beat_result_t;

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [47:0]                    s_axis_tdata;   // [15:0] raw_sample, [47:16] time_ms
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [39:0]                    m_axis_tdata;   // [23:0] smoothed_value, [39:24] beats_per_minute
    logic [0:0]                     m_axis_tuser;   // [0] rate_valid
    logic                           cfg_we;
    logic [pprd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pprd_pkg::CFG_W-1:0]     cfg_data;

    pulse_peak_rate_detector_top #(
        .MAX_WINDOW (WINDOW_MAX)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Mirror of the block state and registers
    // ------------------------------------------------------------------
    logic [pprd_pkg::SAMPLE_W-1:0] ring_copy [WINDOW_MAX];
    logic [pprd_pkg::SUM_W-1:0]    ring_sum;
    int unsigned                   ring_pos;
    int unsigned                   window_len;
    logic [pprd_pkg::THR_W-1:0]    level_thr;
    logic [pprd_pkg::REFR_W-1:0]   refractory_ms;
    logic [pprd_pkg::SMOOTH_W-1:0] prior_smoothed;
    pprd_pkg::slope_t              slope_now;
    bit                            first_peak_seen;
    bit                            refr_active;
    logic [pprd_pkg::TIME_W-1:0]   peak_stamp;

    beat_result_t        pending_beats [$];
    int unsigned         mismatches = 0;
    int unsigned         cycle_count = 0;
    int unsigned         stall_left;
    bit                  sender_idles;
    bit                  receiver_stalls;

    task automatic clear_ring_copy();
        foreach (ring_copy[i])
            ring_copy[i] = '0;
        ring_sum = '0;
        ring_pos = 0;
    endtask

    task automatic reset_predictor();
        window_len      = WINDOW_AT_RESET;
        level_thr       = THRESH_AT_RESET;
        refractory_ms   = REFRACT_AT_RESET;
        clear_ring_copy();
        prior_smoothed  = '0;
        slope_now       = pprd_pkg::SLOPE_NONE;
        first_peak_seen = 1'b0;
        refr_active     = 1'b0;
        peak_stamp      = '0;
    endtask

    // Advances the mirror by one sample and returns the result it must give.
    function automatic beat_result_t predict_beat(
        input logic [pprd_pkg::SAMPLE_W-1:0] sample,
        input logic [pprd_pkg::TIME_W-1:0]   stamp);
        beat_result_t                beat;
        logic [63:0]                 scaled;
        logic [pprd_pkg::TIME_W-1:0] since_peak;
        logic [pprd_pkg::DIV_W-1:0]  quotient;
        pprd_pkg::slope_t            was;
        beat = '0;
        if (ring_pos >= window_len)
            ring_pos = 0;
        ring_sum = ring_sum - ring_copy[ring_pos] + sample;
        ring_copy[ring_pos] = sample;
        ring_pos = ring_pos + 1;
        if (ring_pos >= window_len)
            ring_pos = 0;

        scaled = (64'(ring_sum) << 8) / 64'(window_len);
        beat.smoothed = scaled[pprd_pkg::SMOOTH_W-1:0];
        since_peak = stamp - peak_stamp;   // wraps mod 2^32

        if (beat.smoothed < level_thr)
        begin
            slope_now = pprd_pkg::SLOPE_NONE;
        end
        else if (!(refr_active && since_peak < pprd_pkg::TIME_W'(refractory_ms)))
        begin
            refr_active = 1'b0;
            was = slope_now;
            if (beat.smoothed > prior_smoothed)
                slope_now = pprd_pkg::SLOPE_RISING;
            else if (beat.smoothed < prior_smoothed)
                slope_now = pprd_pkg::SLOPE_FALLING;
            prior_smoothed = beat.smoothed;
            // rising then falling: a peak
            if (was == pprd_pkg::SLOPE_RISING && slope_now == pprd_pkg::SLOPE_FALLING)
            begin
                if (first_peak_seen)
                begin
                    if (since_peak == '0)
                    begin
                        beat.bpm = '1;
                    end
                    else
                    begin
                        quotient = pprd_pkg::RATE_NUM / since_peak;
                        beat.bpm = (quotient > 32'h0000_FFFF)
                                   ? '1 : quotient[pprd_pkg::BPM_W-1:0];
                    end
                    beat.rate_valid = 1'b1;
                end
                first_peak_seen = 1'b1;
                peak_stamp      = stamp;
                refr_active     = 1'b1;
            end
        end
        return beat;
    endfunction

    // ------------------------------------------------------------------
    // Shared stimulus helpers
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // Register write; mirror follows at the same edge the block takes it.
    task automatic write_reg(input logic [pprd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pprd_pkg::CFG_W-1:0]     value);
        int unsigned w;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            pprd_pkg::CFG_WINDOW:
            begin
                w = 32'(value[pprd_pkg::WIN_W-1:0]);
                if (w == 0)
                    w = 1;
                if (w > WINDOW_MAX)
                    w = WINDOW_MAX;
                window_len = w;
                clear_ring_copy();
            end
            pprd_pkg::CFG_THRESHOLD: level_thr     = value[pprd_pkg::THR_W-1:0];
            pprd_pkg::CFG_REFRACT:   refractory_ms = value[pprd_pkg::REFR_W-1:0];
            default: ;   // no such register
        endcase
        @(posedge clk);
    endtask

    // One input transaction; tvalid stays up if the next one follows at once.
    task automatic push_sample(input logic [pprd_pkg::SAMPLE_W-1:0] sample,
                               input logic [pprd_pkg::TIME_W-1:0]   stamp);
        int unsigned gap;
        gap = sender_idles ? $urandom_range(0, 19) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stamp, sample};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_beats.push_back(predict_beat(sample, stamp));
    endtask

    // Block is idle once every predicted result has come back.
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall per result, check against oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : collect_beats
        beat_result_t want;
        int unsigned  hold;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_beats.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transaction tdata=%h tuser=%b",
                                          m_axis_tdata, m_axis_tuser));
            end
            else
            begin
                want = pending_beats.pop_front();
                if (m_axis_tdata[23:0] !== want.smoothed)
                    report_mismatch($sformatf("smoothed_value got %h want %h",
                                              m_axis_tdata[23:0], want.smoothed));
                if (m_axis_tuser[0] !== want.rate_valid)
                    report_mismatch($sformatf("rate_valid got %b want %b",
                                              m_axis_tuser[0], want.rate_valid));
                if (m_axis_tdata[39:24] !== want.bpm)
                    report_mismatch($sformatf("beats_per_minute got %h want %h",
                                              m_axis_tdata[39:24], want.bpm));
            end
            hold = receiver_stalls ? $urandom_range(0, 19) : 0;
            stall_left    <= hold;
            m_axis_tready <= (hold == 0);
        end
        else if (!m_axis_tready && m_axis_tvalid)
        begin
            // stall counts down only while a result is actually waiting
            if (stall_left <= 1)
            begin
                m_axis_tready <= 1'b1;
                stall_left    <= 0;
            end
            else
            begin
                stall_left <= stall_left - 1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_beats.size());
            $display("** pulse_peak_rate_detector_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers (window 8): zero and full-scale samples, timestamps at
    // both ends, then an equal average that must hold the slope.
    task automatic test_field_extremes();
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        push_sample(16'h0000, 32'h0000_0000);
        push_sample(16'hFFFF, 32'hFFFF_FFFF);
        push_sample(16'hFFFF, 32'h0000_0005);
        push_sample(16'h0000, 32'h0000_000A);
        settle_idle();
    endtask

    // Window 1, no refractory: first peak, saturated rate, zero interval,
    // an ordinary rate, a huge wrapped interval and a peak pair across zero.
    task automatic test_peak_rates();
        write_reg(pprd_pkg::CFG_WINDOW, 24'd1);
        write_reg(pprd_pkg::CFG_REFRACT, 24'd0);
        sender_idles    = 1'b0;
        receiver_stalls = 1'b1;
        push_sample(16'd100, 32'd1000);        // falls after rising: first peak
        push_sample(16'd200, 32'd1010);
        push_sample(16'd150, 32'd1020);        // 20 ms interval saturates
        push_sample(16'd300, 32'd1020);
        push_sample(16'd100, 32'd1020);        // same timestamp as last peak
        push_sample(16'd500, 32'd1600);
        push_sample(16'd20,  32'd2020);        // 1000 ms: 60 bpm
        push_sample(16'd600, 32'hFFFF_FE00);
        push_sample(16'd10,  32'hFFFF_FF00);   // interval close to 2^32: rate 0
        push_sample(16'd700, 32'hFFFF_FFF0);
        push_sample(16'd5,   32'h0000_00F0);   // interval spans the wrap
        settle_idle();
    endtask

    // Samples inside the refractory time are ignored, even a falling one;
    // exactly at the refractory time detection resumes.
    task automatic test_refractory();
        write_reg(pprd_pkg::CFG_REFRACT, 24'd300);
        sender_idles    = 1'b1;
        receiver_stalls = 1'b0;
        push_sample(16'd800, 32'h0000_0100);
        push_sample(16'd5,   32'h0000_0200);
        push_sample(16'd900, 32'h0000_021C);
        push_sample(16'd400, 32'h0000_0300);
        settle_idle();
    endtask

    // Below threshold clears the slope; equal to threshold still proceeds;
    // the top threshold keeps even a full-scale sample below it.
    task automatic test_threshold();
        write_reg(pprd_pkg::CFG_THRESHOLD, 24'd256000);
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        push_sample(16'd2000, 32'h0000_1000);
        push_sample(16'd999,  32'h0000_1100);
        push_sample(16'd1000, 32'h0000_1200);
        settle_idle();
        write_reg(pprd_pkg::CFG_THRESHOLD, 24'hFF_FFFF);
        push_sample(16'hFFFF, 32'h0000_1300);
        settle_idle();
        write_reg(pprd_pkg::CFG_THRESHOLD, 24'd0);
    endtask

    // Window values out of range clamp, bits above the field are dropped,
    // and a write to an index with no register changes nothing.
    task automatic test_window_limits();
        write_reg(CFG_UNUSED, 24'hFF_FFFF);
        write_reg(pprd_pkg::CFG_WINDOW, 24'd0);
        write_reg(pprd_pkg::CFG_WINDOW, 24'd127);
        write_reg(pprd_pkg::CFG_WINDOW, 24'h00_0080);
        write_reg(pprd_pkg::CFG_WINDOW, 24'd65);
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        push_sample(16'hFFFF, 32'h0000_2000);
        push_sample(16'hFFFF, 32'h0000_2010);
        settle_idle();
    endtask

    // Bursts of synthetic pulse waveforms with random content, each register
    // rewritten at random before a burst, plus stray samples and timestamp jumps.
    task automatic test_random_pulses(input int unsigned target);
        int unsigned                 sent;
        int unsigned                 burst;
        int unsigned                 period, rise, base, amp, noise;
        int unsigned                 phase_ms, step, level;
        logic [pprd_pkg::TIME_W-1:0] stamp;
        sent = 0;
        while (sent < target)
        begin
            settle_idle();
            period = $urandom_range(250, 2000);
            rise   = period / $urandom_range(2, 5);
            base   = $urandom_range(0, 40000);
            amp    = $urandom_range(0, 40000);
            noise  = amp / 16 + 1;

            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 9))
                    0:       write_reg(pprd_pkg::CFG_WINDOW, 24'd0);
                    1:       write_reg(pprd_pkg::CFG_WINDOW, 24'd64);
                    2:       write_reg(pprd_pkg::CFG_WINDOW,
                                       pprd_pkg::CFG_W'($urandom_range(0, 24'hFF_FFFF)));
                    3:       write_reg(pprd_pkg::CFG_WINDOW,
                                       pprd_pkg::CFG_W'($urandom_range(65, 127)));
                    default: write_reg(pprd_pkg::CFG_WINDOW,
                                       pprd_pkg::CFG_W'($urandom_range(1, 8)));
                endcase
            end
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 9))
                    0:       write_reg(pprd_pkg::CFG_THRESHOLD, 24'hFF_FFFF);
                    1, 2:    write_reg(pprd_pkg::CFG_THRESHOLD,
                                       pprd_pkg::CFG_W'($urandom_range(0,
                                                        (base + amp / 2) * 256)));
                    3:       write_reg(pprd_pkg::CFG_THRESHOLD,
                                       pprd_pkg::CFG_W'($urandom_range(0, 24'hFF_FFFF)));
                    default: write_reg(pprd_pkg::CFG_THRESHOLD, 24'd0);
                endcase
            end
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 9))
                    0:       write_reg(pprd_pkg::CFG_REFRACT, 24'd0);
                    1:       write_reg(pprd_pkg::CFG_REFRACT, 24'd65535);
                    2:       write_reg(pprd_pkg::CFG_REFRACT,
                                       pprd_pkg::CFG_W'($urandom_range(0, 65535)));
                    default: write_reg(pprd_pkg::CFG_REFRACT,
                                       pprd_pkg::CFG_W'($urandom_range(100, period / 2)));
                endcase
            end

            sender_idles    = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            // sometimes start just short of the timestamp wrap
            stamp    = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 5000)
                                                   : $urandom();
            phase_ms = $urandom_range(0, period - 1);
            burst    = $urandom_range(30, 120);

            repeat (burst)
            begin
                step     = $urandom_range(0, 20);
                stamp    = stamp + step;
                phase_ms = (phase_ms + step) % period;
                if (phase_ms < rise)
                    level = base + amp * phase_ms / rise;
                else
                    level = base + amp * (period - phase_ms) / (period - rise);
                level = level + $urandom_range(0, noise);
                if (level > 65535)
                    level = 65535;   // sensor clips
                if ($urandom_range(0, 19) == 0)
                    level = $urandom_range(0, 65535);
                if ($urandom_range(0, 59) == 0)
                    stamp = $urandom();
                push_sample(pprd_pkg::SAMPLE_W'(level), stamp);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= pprd_pkg::CFG_WINDOW;
        cfg_data      <= '0;
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        reset_predictor();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_peak_rates();
        test_refractory();
        test_threshold();
        test_window_limits();
        test_random_pulses(RANDOM_SAMPLES);

        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_beats.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_beats.size()));

        if (mismatches == 0)
            $display("** pulse_peak_rate_detector_top: PASSED **");
        else
            $display("** pulse_peak_rate_detector_top: FAILED **");
        $finish;
    end

endmodule
